@@ sv/ebcd_pkg.sv @@
package ebcd_pkg;

  localparam int RING_DEPTH_DEF = 256;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  // 64-bit command patterns, aligned after the leading ones are stripped
  localparam logic [63:0] PAT_GO_IDLE     = 64'h4000_0000_0095_ffff;
  localparam logic [63:0] PAT_GO_PRE_IDLE = 64'h40f0_f0f0_f0fd_ffff;
  localparam logic [63:0] PAT_BOOT_INIT   = 64'h40ff_ffff_fae5_ffff;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_GO_IDLE  = 2'd1;
  localparam logic [1:0] CMD_PRE_IDLE = 2'd2;
  localparam logic [1:0] CMD_BOOT     = 2'd3;

  localparam logic [1:0] STAT_PARSED = 2'd0;
  localparam logic [1:0] STAT_BUSY   = 2'd1;
  localparam logic [1:0] STAT_MISSED = 2'd2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] rx_word;
  } in_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] command_found;
    logic [1:0] scan_status;
    logic       transfer_active;
  } out_t;

  typedef struct packed {
    logic       done;
    logic [1:0] cmd;
  } parse_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST_RD,
    S_LAST_CHK,
    S_BACK_RD,
    S_BACK_CHK,
    S_FWD_RD,
    S_FWD_CHK,
    S_W0_RD,
    S_W1_RD,
    S_W2_RD,
    S_W_CAP,
    S_PARSE,
    S_EMIT
  } state_t;

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

@@ sv/ebcd_ram.sv @@
module ebcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/ebcd_parse.sv @@
module ebcd_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [31:0]            w0,
  input  logic [31:0]            w1,
  input  logic [31:0]            w2,
  output ebcd_pkg::parse_res_t   res
);
  import ebcd_pkg::*;

  logic        busy_r, busy_nxt;
  logic        err_r, err_nxt;
  logic [95:0] sh_r, sh_nxt;
  logic        done;
  logic [1:0]  cmd;

  // strip leading ones one bit per cycle; a first word of all ones sets the error flag and gives no command
  assign done = busy_r && (err_r || !sh_r[95]);

  always_comb begin
    cmd = CMD_NONE;
    if (!err_r) begin
      if (sh_r[95:32] == PAT_GO_IDLE) begin
        cmd = CMD_GO_IDLE;
      end else if (sh_r[95:32] == PAT_GO_PRE_IDLE) begin
        cmd = CMD_PRE_IDLE;
      end else if (sh_r[95:32] == PAT_BOOT_INIT) begin
        cmd = CMD_BOOT;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    err_nxt  = err_r;
    sh_nxt   = sh_r;
    if (start) begin
      busy_nxt = 1'b1;
      err_nxt  = (w0 == ALL_ONES);
      sh_nxt   = {swap_bytes(w0), swap_bytes(w1), swap_bytes(w2)};
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      sh_nxt = {sh_r[94:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    err_r <= err_nxt;
    sh_r  <= sh_nxt;
  end

  assign res.done = done;
  assign res.cmd  = cmd;

endmodule

@@ sv/emmc_boot_command_detector.sv @@
// eMMC boot command detector. A store transfer (operation 0) writes rx_word into a ring of
// RING_DEPTH words. An event transfer (operation 1) runs a scan through the ring's single
// read port: one look at the newest word, a backward pass over all-ones words, a short
// forward pass, three word reads, then a shifter that strips the command's leading ones one
// bit per cycle (up to 31). Each event gives one result; stores give none. The ring reads as
// zero until written, with no clearing pass after reset. Input is not taken while a scan
// runs, but stores and new events are taken while a finished result waits on the output.
module emmc_boot_command_detector #(
  parameter int RING_DEPTH = ebcd_pkg::RING_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ebcd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ebcd_pkg::out_t out_data
);
  import ebcd_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  state_t          state_r, state_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic            wrapped_r, wrapped_nxt;
  logic            xfer_r, xfer_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [31:0]     w0_r, w0_nxt;
  logic [31:0]     w1_r, w1_nxt;
  out_t            res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r, out_data_nxt;
  logic            rvalid_r;

  logic            in_fire;
  logic            ram_we;
  logic [AW-1:0]   raddr;
  logic [31:0]     ram_rdata;
  logic [31:0]     rd_word;
  logic            rd_ones;
  logic            parse_start;
  parse_res_t      pres;
  logic            out_load;
  logic [AW-1:0]   idx_prev, idx_prev2, idx_next;

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    ring_prev = (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign ram_we   = in_fire && (in_data.operation == OP_STORE);

  assign idx_prev  = ring_prev(idx_r);
  assign idx_prev2 = ring_prev(idx_prev);
  assign idx_next  = ring_next(idx_r);

  // entries past the write pointer before the first wrap were never written: read as zero
  assign rd_word = rvalid_r ? ram_rdata : '0;
  assign rd_ones = (rd_word == ALL_ONES);

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  ebcd_ram #(
    .WIDTH(32),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_data.rx_word),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  ebcd_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .start (parse_start),
    .w0    (w0_r),
    .w1    (w1_r),
    .w2    (rd_word),
    .res   (pres)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_data.operation == OP_EVENT)) state_nxt = S_LAST_RD;
      end
      S_LAST_RD:  state_nxt = S_LAST_CHK;
      S_LAST_CHK: state_nxt = rd_ones ? S_BACK_RD : S_EMIT;
      S_BACK_RD:  state_nxt = (idx_r == wp_r) ? S_EMIT : S_BACK_CHK;
      S_BACK_CHK: state_nxt = rd_ones ? S_BACK_RD : S_FWD_RD;
      S_FWD_RD:   state_nxt = (idx_r == wp_r) ? S_W0_RD : S_FWD_CHK;
      S_FWD_CHK:  state_nxt = rd_ones ? S_FWD_RD : S_W0_RD;
      S_W0_RD:    state_nxt = S_W1_RD;
      S_W1_RD:    state_nxt = S_W2_RD;
      S_W2_RD:    state_nxt = S_W_CAP;
      S_W_CAP:    state_nxt = S_PARSE;
      S_PARSE: begin
        if (pres.done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wp_nxt       = wp_r;
    wrapped_nxt  = wrapped_r;
    xfer_nxt     = xfer_r;
    idx_nxt      = idx_r;
    w0_nxt       = w0_r;
    w1_nxt       = w1_r;
    res_nxt      = res_r;
    raddr        = idx_r;
    parse_start  = 1'b0;
    out_data_nxt = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (ram_we) begin
          wp_nxt = ring_next(wp_r);
          if (wp_r == LAST_IDX) wrapped_nxt = 1'b1;
        end
        idx_nxt = ring_prev(wp_r);
        res_nxt = '{action: ACT_NONE, command_found: CMD_NONE,
                    scan_status: STAT_PARSED, transfer_active: 1'b0};
      end
      S_LAST_RD: ;
      S_LAST_CHK: begin
        if (rd_ones) begin
          idx_nxt = idx_prev;
        end else begin
          res_nxt.scan_status = STAT_BUSY;
        end
      end
      S_BACK_RD: begin
        if (idx_r == wp_r) res_nxt.scan_status = STAT_MISSED;
      end
      S_BACK_CHK: begin
        idx_nxt = rd_ones ? idx_prev : idx_prev2;
      end
      S_FWD_RD: ;
      S_FWD_CHK: begin
        if (rd_ones) idx_nxt = idx_next;
      end
      S_W0_RD: begin
        idx_nxt = idx_next;
      end
      S_W1_RD: begin
        w0_nxt  = rd_word;
        idx_nxt = idx_next;
      end
      S_W2_RD: begin
        w1_nxt = rd_word;
      end
      S_W_CAP: begin
        parse_start = 1'b1;
      end
      S_PARSE: begin
        if (pres.done) begin
          res_nxt.command_found = pres.cmd;
          if (!xfer_r && (pres.cmd == CMD_BOOT)) begin
            xfer_nxt       = 1'b1;
            res_nxt.action = ACT_START;
          end else if (xfer_r && ((pres.cmd == CMD_GO_IDLE) ||
                                  (pres.cmd == CMD_PRE_IDLE))) begin
            xfer_nxt       = 1'b0;
            res_nxt.action = ACT_STOP;
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_data_nxt                 = res_r;
          out_data_nxt.transfer_active = xfer_r;
        end
      end
      default: ;
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      xfer_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      xfer_r      <= xfer_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    w0_r       <= w0_nxt;
    w1_r       <= w1_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    rvalid_r   <= wrapped_r || (raddr < wp_r);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ebcd_pkg::*;

  localparam int    RING         = RING_DEPTH_DEF;
  localparam int    CLK_PERIOD   = 10;
  localparam int    RANDOM_ITEMS = 450;
  localparam int    DRAIN_CYCLES = 4 * RING_DEPTH_DEF + 64;
  localparam longint LIMIT_CYCLES = 4_000_000;
  localparam int    HOLD_CYCLES  = 600;

  typedef enum logic [1:0] {
    ROW_STORE,
    ROW_EVENT,
    ROW_FRAME,
    ROW_FILL
  } row_kind_t;

  // value: stored word, or the 64-bit command for a frame
  // count: leading ones for a frame, repetitions for a fill
  typedef struct packed {
    row_kind_t   kind;
    logic [63:0] value;
    int          count;
    bit          typed;
    out_t        outcome;
  } directed_row_t;

  localparam out_t NOT_TYPED   = '0;
  localparam out_t BUS_BUSY    = '{ACT_NONE, CMD_NONE, STAT_BUSY, 1'b0};
  localparam out_t CMD_MISSED  = '{ACT_NONE, CMD_NONE, STAT_MISSED, 1'b0};
  localparam out_t ONES_AT_TOP = '{ACT_NONE, CMD_NONE, STAT_PARSED, 1'b0};

  localparam int NUM_ROWS = 19;
  localparam directed_row_t DIRECTED_ROWS[NUM_ROWS] = '{
    '{ROW_EVENT, 64'd0, 0, 1'b1, BUS_BUSY},       // ring still cleared
    '{ROW_STORE, 64'd0, 0, 1'b0, NOT_TYPED},
    '{ROW_EVENT, 64'd0, 0, 1'b1, BUS_BUSY},
    '{ROW_STORE, {32'd0, ALL_ONES}, 0, 1'b0, NOT_TYPED},
    '{ROW_EVENT, 64'd0, 0, 1'b0, NOT_TYPED},
    '{ROW_STORE, 64'h8000_0000, 0, 1'b0, NOT_TYPED},
    '{ROW_EVENT, 64'd0, 0, 1'b1, BUS_BUSY},
    '{ROW_FILL, {32'd0, ALL_ONES}, RING, 1'b0, NOT_TYPED},
    '{ROW_EVENT, 64'd0, 0, 1'b1, CMD_MISSED},     // whole ring idle
    '{ROW_STORE, 64'd0, 0, 1'b0, NOT_TYPED},
    '{ROW_FILL, {32'd0, ALL_ONES}, RING - 2, 1'b0, NOT_TYPED},
    '{ROW_EVENT, 64'd0, 0, 1'b1, ONES_AT_TOP},    // forward pass ends on an idle word
    '{ROW_FRAME, PAT_GO_IDLE, 0, 1'b0, NOT_TYPED},
    '{ROW_FRAME, PAT_GO_PRE_IDLE, 31, 1'b0, NOT_TYPED},
    '{ROW_FRAME, PAT_BOOT_INIT, 17, 1'b0, NOT_TYPED},
    '{ROW_FRAME, PAT_BOOT_INIT, 18, 1'b0, NOT_TYPED},
    '{ROW_FRAME, PAT_GO_IDLE, 5, 1'b0, NOT_TYPED},
    '{ROW_FRAME, PAT_BOOT_INIT, 31, 1'b0, NOT_TYPED},
    '{ROW_FRAME, PAT_GO_PRE_IDLE ^ 64'h0000_0100_0000_0000, 9, 1'b0, NOT_TYPED}
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // shadow copy of the detector's state
  logic [31:0] shadow_ring[RING];
  int          shadow_wp;
  logic        shadow_xfer;

  out_t   pending_outcomes[$];
  out_t   oldest_outcome;
  int     error_count;
  int     items_sent;
  int     events_sent;
  int     results_seen;
  int     starts_seen;
  int     stops_seen;
  int     missed_seen;
  int     busy_seen;
  longint cycle_count;
  bit     hold_done;

  emmc_boot_command_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_top: errors");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [31:0] byte_reverse(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [1:0] decode_command(input int pos);
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [95:0] bits;
    logic [63:0] head;
    int          ones;
    if (shadow_ring[pos] == ALL_ONES) return CMD_NONE;
    w0 = byte_reverse(shadow_ring[pos]);
    w1 = byte_reverse(shadow_ring[(pos + 1) % RING]);
    w2 = byte_reverse(shadow_ring[(pos + 2) % RING]);
    ones = 0;
    while (ones < 31 && w0[31 - ones]) ones++;
    bits = {w0, w1, w2} << ones;
    head = bits[95:32];
    if (head == PAT_GO_IDLE) return CMD_GO_IDLE;
    if (head == PAT_GO_PRE_IDLE) return CMD_PRE_IDLE;
    if (head == PAT_BOOT_INIT) return CMD_BOOT;
    return CMD_NONE;
  endfunction

  function automatic out_t scan_event();
    out_t res;
    int   idx;
    res = '{ACT_NONE, CMD_NONE, STAT_PARSED, 1'b0};
    idx = (shadow_wp + RING - 1) % RING;
    if (shadow_ring[idx] != ALL_ONES) begin
      res.scan_status = STAT_BUSY;
    end else begin
      while (idx != shadow_wp && shadow_ring[idx] == ALL_ONES) idx = (idx + RING - 1) % RING;
      if (idx == shadow_wp) begin
        res.scan_status = STAT_MISSED;
      end else begin
        // back two words, then forward to the command's first word
        idx = (idx + RING - 2) % RING;
        while (idx != shadow_wp && shadow_ring[idx] == ALL_ONES) idx = (idx + 1) % RING;
        res.command_found = decode_command(idx);
        if (!shadow_xfer) begin
          if (res.command_found == CMD_BOOT) begin
            shadow_xfer = 1'b1;
            res.action = ACT_START;
          end
        end else if (res.command_found == CMD_GO_IDLE || res.command_found == CMD_PRE_IDLE) begin
          shadow_xfer = 1'b0;
          res.action = ACT_STOP;
        end
      end
    end
    res.transfer_active = shadow_xfer;
    return res;
  endfunction

  task automatic idle_gap();
    int r;
    int g;
    if (((items_sent / 128) % 4) == 2) return;
    r = $urandom_range(0, 99);
    if (r < 55) return;
    g = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    in_valid = 1'b0;
    repeat (g) @(negedge clk);
  endtask

  // entered and left at a falling edge
  task automatic offer(input in_t item, input bit typed, input out_t typed_outcome);
    out_t outcome;
    in_valid = 1'b1;
    in_data = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.operation == OP_STORE) begin
      shadow_ring[shadow_wp] = item.rx_word;
      shadow_wp = (shadow_wp + 1) % RING;
    end else begin
      outcome = scan_event();
      pending_outcomes.push_back(typed ? typed_outcome : outcome);
      events_sent++;
    end
    items_sent++;
    @(negedge clk);
    idle_gap();
  endtask

  task automatic send_store(input logic [31:0] word);
    offer('{OP_STORE, word}, 1'b0, NOT_TYPED);
  endtask

  task automatic send_event();
    offer('{OP_EVENT, 32'($urandom())}, 1'b0, NOT_TYPED);
  endtask

  // idle padding, the first words of the command stream, idle tail
  task automatic send_frame(input logic [63:0] pattern, input int lead, input int pad,
                            input int words, input int tail);
    logic [95:0] bits;
    int          k;
    bits = '1;
    bits[95 - lead -: 64] = pattern;
    repeat (pad) send_store(ALL_ONES);
    for (k = 0; k < words; k++) send_store(byte_reverse(bits[95 - 32 * k -: 32]));
    repeat (tail) send_store(ALL_ONES);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_data);
        error_count++;
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        results_seen++;
        if (oldest_outcome.action == ACT_START) starts_seen++;
        if (oldest_outcome.action == ACT_STOP) stops_seen++;
        if (oldest_outcome.scan_status == STAT_MISSED) missed_seen++;
        if (oldest_outcome.scan_status == STAT_BUSY) busy_seen++;
        if (out_data.action !== oldest_outcome.action) begin
          $error("action: expected %0d, got %0d", oldest_outcome.action, out_data.action);
          error_count++;
        end
        if (out_data.command_found !== oldest_outcome.command_found) begin
          $error("command_found: expected %0d, got %0d",
                 oldest_outcome.command_found, out_data.command_found);
          error_count++;
        end
        if (out_data.scan_status !== oldest_outcome.scan_status) begin
          $error("scan_status: expected %0d, got %0d",
                 oldest_outcome.scan_status, out_data.scan_status);
          error_count++;
        end
        if (out_data.transfer_active !== oldest_outcome.transfer_active) begin
          $error("transfer_active: expected %0d, got %0d",
                 oldest_outcome.transfer_active, out_data.transfer_active);
          error_count++;
        end
      end
    end
  end

  initial begin : result_side
    int r;
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 30) begin
        // long back-pressure while the sender keeps going
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (((cycle_count / 400) % 5) == 4) begin
        out_ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready = 1'b1;
        end else begin
          out_ready = 1'b0;
          stall = (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin : input_side
    int          rand_start;
    int          r;
    int          lead;
    logic [63:0] pattern;
    bit          drained_once;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    items_sent = 0;
    events_sent = 0;
    results_seen = 0;
    starts_seen = 0;
    stops_seen = 0;
    missed_seen = 0;
    busy_seen = 0;
    cycle_count = 0;
    hold_done = 1'b0;
    drained_once = 1'b0;
    foreach (shadow_ring[k]) shadow_ring[k] = '0;
    shadow_wp = 0;
    shadow_xfer = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (DIRECTED_ROWS[n]) begin
      case (DIRECTED_ROWS[n].kind)
        ROW_STORE: send_store(DIRECTED_ROWS[n].value[31:0]);
        ROW_EVENT: offer('{OP_EVENT, 32'($urandom())}, DIRECTED_ROWS[n].typed,
                         DIRECTED_ROWS[n].outcome);
        ROW_FRAME: begin
          send_frame(DIRECTED_ROWS[n].value, DIRECTED_ROWS[n].count, 1, 3, 1);
          send_event();
        end
        ROW_FILL: repeat (DIRECTED_ROWS[n].count) send_store(DIRECTED_ROWS[n].value[31:0]);
        default: ;
      endcase
    end

    rand_start = items_sent;
    while (items_sent < rand_start + RANDOM_ITEMS) begin
      if (!drained_once && items_sent >= rand_start + RANDOM_ITEMS / 2) begin
        // sender waits for every outstanding result
        drained_once = 1'b1;
        in_valid = 1'b0;
        while (pending_outcomes.size() != 0) @(negedge clk);
      end
      r = $urandom_range(0, 999);
      lead = ($urandom_range(0, 4) == 0) ? 31 * $urandom_range(0, 1) : $urandom_range(0, 31);
      case ($urandom_range(0, 2))
        0: pattern = PAT_GO_IDLE;
        1: pattern = PAT_GO_PRE_IDLE;
        default: pattern = PAT_BOOT_INIT;
      endcase
      if (r < 560) begin
        if ($urandom_range(0, 6) == 0) pattern ^= 64'd1 << $urandom_range(0, 63);
        send_frame(pattern, lead, $urandom_range(0, 3), 3, $urandom_range(0, 2));
        send_event();
      end else if (r < 760) begin
        repeat ($urandom_range(1, 4)) begin
          send_store(($urandom_range(0, 3) == 0) ? ALL_ONES : 32'($urandom()));
        end
        if ($urandom_range(0, 1)) send_event();
      end else if (r < 860) begin
        // truncated command
        send_frame(pattern, lead, $urandom_range(0, 2), $urandom_range(1, 2),
                   $urandom_range(0, 2));
        send_event();
      end else if (r < 994) begin
        send_event();
      end else begin
        // long idle run, reaching back to the write pointer or close to it
        send_store(32'($urandom()));
        repeat ($urandom_range(RING - 6, RING)) send_store(ALL_ONES);
        send_event();
      end
    end
    in_valid = 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d input transfers, %0d command events, %0d results checked",
             items_sent, events_sent, results_seen);
    $display("run: %0d boot starts, %0d stops, %0d missed, %0d bus busy",
             starts_seen, stops_seen, missed_seen, busy_seen);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
